[rtl/touch_pen_event_queue_scaler_top_defines.svh]
// Assertion macros shared by the touch event queue RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef TOUCH_PEN_EVENT_QUEUE_SCALER_TOP_DEFINES_SVH
`define TOUCH_PEN_EVENT_QUEUE_SCALER_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define TPEQ_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define TPEQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/tpeq_pkg.sv]
// Shared types, widths and constants for the touch event queue.
// No dependencies; imported by every other file but the macros header.
package tpeq_pkg;

   // queue geometry
   localparam int EVENT_DEPTH = 32;
   localparam int PTR_W       = $clog2(EVENT_DEPTH);
   localparam int CNT_W       = $clog2(EVENT_DEPTH + 1);

   // field widths
   localparam int RAW_W      = 10;
   localparam int SIZE_W     = 11;
   localparam int COORD_W    = 11;
   localparam int POS_W      = 16;
   localparam int BTN_W      = 3;
   localparam int COUNT_W    = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_X_MAX         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_SPAN        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_MAX         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_SPAN        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_FLIP_BASE   = 3'd6;

   // register reset values
   localparam logic [RAW_W-1:0]  X_MAX_RST         = 10'd940;
   localparam logic [RAW_W-1:0]  X_SPAN_RST        = 10'd865;
   localparam logic [RAW_W-1:0]  Y_MAX_RST         = 10'd875;
   localparam logic [RAW_W-1:0]  Y_SPAN_RST        = 10'd875;
   localparam logic [SIZE_W-1:0] SCREEN_WIDTH_RST  = 11'd640;
   localparam logic [SIZE_W-1:0] SCREEN_HEIGHT_RST = 11'd480;
   localparam logic [RAW_W-1:0]  Y_FLIP_BASE_RST   = 10'd935;

   // button codes
   localparam logic [BTN_W-1:0] BTN_DOWN = 3'd4;
   localparam logic [BTN_W-1:0] BTN_UP   = 3'd0;

   // one queued pen event
   typedef struct packed {
      logic                      down;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } event_type;

   // scaling request to the shared arithmetic unit
   typedef struct packed {
      logic                      start;
      logic signed [COORD_W-1:0] raw;
      logic [RAW_W-1:0]          maxv;
      logic [RAW_W-1:0]          span;
      logic [SIZE_W-1:0]         size;
   } scale_req_type;

   // queue control and status
   typedef struct packed {
      logic push;
      logic pop;
   } q_ctrl_type;

   typedef struct packed {
      logic             full;
      logic             empty;
      logic [CNT_W-1:0] count;
   } q_stat_type;

endpackage

[rtl/tpeq_if.sv]
// Valid/ready channel interfaces: request, response and register write.
// Depends on tpeq_pkg for field widths.
interface tpeq_req_if import tpeq_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             action;
   logic             adc_pending;
   logic             touch_pending;
   logic             up_flag_a;
   logic             up_flag_b;
   logic [RAW_W-1:0] raw_x;
   logic [RAW_W-1:0] raw_y;

   modport source (output valid, action, adc_pending, touch_pending, up_flag_a,
                   up_flag_b, raw_x, raw_y, input ready);
   modport sink   (input valid, action, adc_pending, touch_pending, up_flag_a,
                   up_flag_b, raw_x, raw_y, output ready);
endinterface

interface tpeq_rsp_if import tpeq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    read_valid;
   logic [BTN_W-1:0]        pen_button;
   logic signed [POS_W-1:0] x_pos;
   logic signed [POS_W-1:0] y_pos;
   logic                    event_stored;
   logic [COUNT_W-1:0]      event_count;

   modport source (output valid, read_valid, pen_button, x_pos, y_pos,
                   event_stored, event_count, input ready);
   modport sink   (input valid, read_valid, pen_button, x_pos, y_pos,
                   event_stored, event_count, output ready);
endinterface

interface tpeq_csr_if import tpeq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/tpeq_queue.sv]
// Ring queue of pen events with registered read data.
// Depends on tpeq_pkg and the assertion macros header.
`include "touch_pen_event_queue_scaler_top_defines.svh"

module tpeq_queue import tpeq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  q_ctrl_type ctrl,
   input  event_type  wr_data,
   output event_type  rd_data,
   output q_stat_type stat
);

   event_type        mem [EVENT_DEPTH];
   event_type        rd_data_ff;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             full, empty, push_ok, pop_ok;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(EVENT_DEPTH - 1)) begin
         ptr_next = '0;
      end else begin
         ptr_next = p + 1'b1;
      end
   endfunction

   assign full    = (count_ff == CNT_W'(EVENT_DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = ctrl.push && !full;
   assign pop_ok  = ctrl.pop && !empty;

   // advance pointers and count
   always_comb begin
      wr_ptr_in = push_ok ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store an item on push
   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

   // fetch the oldest item on pop
   always_ff @(posedge clock) begin
      if (pop_ok) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   assign rd_data     = rd_data_ff;
   assign stat.full   = full;
   assign stat.empty  = empty;
   assign stat.count  = count_ff;

   `TPEQ_ASSERT_SAME(a_q_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(EVENT_DEPTH), "queue count beyond depth")
   `TPEQ_ASSERT_NEXT(a_q_push_count, clock, reset, push_ok, count_ff == $past(count_ff) + 1'b1, "push did not raise count")
   `TPEQ_ASSERT_NEXT(a_q_pop_count, clock, reset, pop_ok, count_ff == $past(count_ff) - 1'b1, "pop did not lower count")
   `TPEQ_ASSERT_SAME(a_q_full_ptrs, clock, reset, full || empty, wr_ptr_ff == rd_ptr_ff, "pointers disagree with count")

endmodule

[rtl/tpeq_scaler.sv]
// Shared scaling unit: computes size - ((max - raw) * size) / span.
// One multiply, then a radix-4 restoring divider. Depends on tpeq_pkg.
module tpeq_scaler import tpeq_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  scale_req_type           req,
   output logic                    done,
   output logic signed [POS_W-1:0] pos
);

   localparam int DIFF_W    = 12;
   localparam int PROD_W    = 24;
   localparam int MAG_W     = 22;
   localparam int DIV_STEPS = MAG_W / 2;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam logic [2:0] SC_IDLE = 3'd0;
   localparam logic [2:0] SC_MUL  = 3'd1;
   localparam logic [2:0] SC_ABS  = 3'd2;
   localparam logic [2:0] SC_DIV  = 3'd3;
   localparam logic [2:0] SC_FIN  = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic [SIZE_W-1:0]        size_ff, size_in;
   logic [RAW_W-1:0]         span_ff, span_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     neg_ff, neg_in;
   logic [MAG_W-1:0]         dvd_ff, dvd_in;
   logic [RAW_W-1:0]         rem_ff, rem_in;
   logic [STEP_W-1:0]        cnt_ff, cnt_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic                     done_ff, done_in;
   logic [RAW_W:0]           step_a, step_b;
   logic signed [MAG_W:0]    quot;
   logic signed [PROD_W-1:0] res;

   // one restoring step: {quotient bit, remainder}
   function automatic logic [RAW_W:0] div_step(input logic [RAW_W-1:0] rem,
                                               input logic bit_in,
                                               input logic [RAW_W-1:0] dsor);
      logic [RAW_W:0] trial;
      logic [RAW_W:0] sub;
      trial = {rem, bit_in};
      sub   = trial - {1'b0, dsor};
      if (trial >= {1'b0, dsor}) begin
         div_step = {1'b1, sub[RAW_W-1:0]};
      end else begin
         div_step = {1'b0, trial[RAW_W-1:0]};
      end
   endfunction

   always_comb begin
      state_in = state_ff;
      diff_in  = diff_ff;
      size_in  = size_ff;
      span_in  = span_ff;
      prod_in  = prod_ff;
      neg_in   = neg_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      done_in  = 1'b0;
      step_a   = div_step(rem_ff, dvd_ff[MAG_W-1], span_ff);
      step_b   = div_step(step_a[RAW_W-1:0], dvd_ff[MAG_W-2], span_ff);
      quot     = neg_ff ? -$signed({1'b0, dvd_ff}) : $signed({1'b0, dvd_ff});
      res      = $signed({{(PROD_W-SIZE_W){1'b0}}, size_ff})
                 - $signed({{(PROD_W-MAG_W-1){quot[MAG_W]}}, quot});
      case (state_ff)
         SC_IDLE: begin
            // capture operands; a zero span divides by one
            if (req.start) begin
               diff_in  = $signed({2'b00, req.maxv}) - $signed({req.raw[COORD_W-1], req.raw});
               size_in  = req.size;
               span_in  = (req.span == '0) ? RAW_W'(1) : req.span;
               state_in = SC_MUL;
            end
         end
         SC_MUL: begin
            prod_in  = diff_ff * $signed({1'b0, size_ff});
            state_in = SC_ABS;
         end
         SC_ABS: begin
            neg_in   = prod_ff[PROD_W-1];
            dvd_in   = prod_ff[PROD_W-1] ? MAG_W'(-prod_ff) : prod_ff[MAG_W-1:0];
            rem_in   = '0;
            cnt_in   = '0;
            state_in = SC_DIV;
         end
         SC_DIV: begin
            // two quotient bits per cycle, shifted in below the dividend
            dvd_in = {dvd_ff[MAG_W-3:0], step_a[RAW_W], step_b[RAW_W]};
            rem_in = step_b[RAW_W-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = SC_FIN;
            end
         end
         SC_FIN: begin
            pos_in   = res[POS_W-1:0];
            done_in  = 1'b1;
            state_in = SC_IDLE;
         end
         default: begin
            state_in = SC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      size_ff <= size_in;
      span_ff <= span_in;
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      pos_ff  <= pos_in;
   end

   assign done = done_ff;
   assign pos  = $signed(pos_ff);

endmodule

[rtl/touch_pen_event_queue_scaler_top.sv]
// Touch-panel front end: pen state tracking, 32-entry event queue and
// screen scaling of queued events on read.
// Channels: req_chan takes one item per handshake, action 0 for an
// interrupt (pending bits, pen-up flags, raw X/Y), action 1 to pop and
// scale one queued event. rsp_chan returns exactly one item per request.
// csr_chan writes the seven scaling registers (index 0..6, others ignored);
// it is always ready and is meant to be written while the block is idle.
// Sequence: an interrupt item or a read of an empty queue goes from idle
// straight to the done state. A read that pops an event first reads the
// queue, then X and Y each pass the shared scaling unit (multiply,
// magnitude, 11 radix-4 divide steps, final subtract).
// Throughput: one item at a time; req_chan.ready is high only while idle.
// A finished result sits in an output register, so the next item is taken
// while it waits; the next result then waits until rsp_chan.ready.
// Reset (synchronous, active high) restores register defaults, clears pen
// and report flags, the last point and the queue pointers and count.
// Depends on tpeq_pkg, tpeq_if, tpeq_queue, tpeq_scaler and the macros.
`include "touch_pen_event_queue_scaler_top_defines.svh"

module touch_pen_event_queue_scaler_top import tpeq_pkg::*; (
   input logic       clock,
   input logic       reset,
   tpeq_req_if.sink  req_chan,
   tpeq_rsp_if.source rsp_chan,
   tpeq_csr_if.sink  csr_chan
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOAD = 3'd1;
   localparam logic [2:0] S_X    = 3'd2;
   localparam logic [2:0] S_Y    = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   // scaling registers
   logic [RAW_W-1:0]  x_max_ff, x_span_ff, y_max_ff, y_span_ff, y_flip_base_ff;
   logic [SIZE_W-1:0] screen_width_ff, screen_height_ff;

   // pen tracking
   logic                      pen_ff, pen_in;
   logic                      rep_ff, rep_in;
   logic signed [COORD_W-1:0] last_x_ff, last_x_in;
   logic signed [COORD_W-1:0] last_y_ff, last_y_in;
   logic signed [COORD_W-1:0] px, py;

   // sequencer and result staging
   logic [2:0]              state_ff, state_in;
   logic                    res_valid_ff, res_valid_in;
   logic                    res_stored_ff, res_stored_in;
   logic signed [POS_W-1:0] res_x_ff, res_x_in;
   logic signed [POS_W-1:0] res_y_ff, res_y_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_read_valid_ff;
   logic [BTN_W-1:0]        rsp_button_ff;
   logic signed [POS_W-1:0] rsp_x_ff, rsp_y_ff;
   logic                    rsp_stored_ff;
   logic [COUNT_W-1:0]      rsp_count_ff;
   logic                    rsp_load;

   logic                    req_accept;
   q_ctrl_type              q_ctrl;
   q_stat_type              q_stat;
   event_type               q_wr_data, q_rd_data;
   scale_req_type           sc_req;
   logic                    sc_done;
   logic signed [POS_W-1:0] sc_pos;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         x_max_ff         <= X_MAX_RST;
         x_span_ff        <= X_SPAN_RST;
         y_max_ff         <= Y_MAX_RST;
         y_span_ff        <= Y_SPAN_RST;
         screen_width_ff  <= SCREEN_WIDTH_RST;
         screen_height_ff <= SCREEN_HEIGHT_RST;
         y_flip_base_ff   <= Y_FLIP_BASE_RST;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_X_MAX:         x_max_ff         <= csr_chan.data[RAW_W-1:0];
            CSR_X_SPAN:        x_span_ff        <= csr_chan.data[RAW_W-1:0];
            CSR_Y_MAX:         y_max_ff         <= csr_chan.data[RAW_W-1:0];
            CSR_Y_SPAN:        y_span_ff        <= csr_chan.data[RAW_W-1:0];
            CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_chan.data[SIZE_W-1:0];
            CSR_SCREEN_HEIGHT: screen_height_ff <= csr_chan.data[SIZE_W-1:0];
            CSR_Y_FLIP_BASE:   y_flip_base_ff   <= csr_chan.data[RAW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // interrupt handling: converter-done first, then touch change
   always_comb begin
      pen_in    = pen_ff;
      rep_in    = rep_ff;
      last_x_in = last_x_ff;
      last_y_in = last_y_ff;
      px        = last_x_ff;
      py        = last_y_ff;
      if (req_chan.adc_pending) begin
         rep_in = 1'b1;
         if (req_chan.up_flag_a || req_chan.up_flag_b) begin
            pen_in = 1'b0;
         end
         if (pen_in) begin
            px        = $signed({1'b0, req_chan.raw_x});
            py        = $signed({1'b0, y_flip_base_ff}) - $signed({1'b0, req_chan.raw_y});
            last_x_in = px;
            last_y_in = py;
         end
      end
      if (req_chan.touch_pending) begin
         if (!req_chan.up_flag_a && !req_chan.up_flag_b) begin
            rep_in = 1'b0;
            pen_in = 1'b1;
         end else begin
            rep_in = 1'b1;
            pen_in = 1'b0;
         end
         px = last_x_in;
         py = last_y_in;
      end
   end

   // queue control
   assign q_wr_data.down = pen_in;
   assign q_wr_data.x    = px;
   assign q_wr_data.y    = py;
   assign q_ctrl.push    = req_accept && !req_chan.action && rep_in && !q_stat.full;
   assign q_ctrl.pop     = req_accept && req_chan.action && !q_stat.empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff    <= 1'b0;
         rep_ff    <= 1'b0;
         last_x_ff <= '0;
         last_y_ff <= '0;
      end else if (req_accept && !req_chan.action) begin
         pen_ff    <= pen_in;
         rep_ff    <= rep_in;
         last_x_ff <= last_x_in;
         last_y_ff <= last_y_in;
      end
   end

   tpeq_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (q_ctrl),
      .wr_data (q_wr_data),
      .rd_data (q_rd_data),
      .stat    (q_stat)
   );

   // feed the shared unit: X after the queue read, Y after X
   always_comb begin
      sc_req.start = (state_ff == S_LOAD) || ((state_ff == S_X) && sc_done);
      if (state_ff == S_LOAD) begin
         sc_req.raw  = q_rd_data.x;
         sc_req.maxv = x_max_ff;
         sc_req.span = x_span_ff;
         sc_req.size = screen_width_ff;
      end else begin
         sc_req.raw  = q_rd_data.y;
         sc_req.maxv = y_max_ff;
         sc_req.span = y_span_ff;
         sc_req.size = screen_height_ff;
      end
   end

   tpeq_scaler u_scaler (
      .clock (clock),
      .reset (reset),
      .req   (sc_req),
      .done  (sc_done),
      .pos   (sc_pos)
   );

   // sequencer
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in      = state_ff;
      res_valid_in  = res_valid_ff;
      res_stored_in = res_stored_ff;
      res_x_in      = res_x_ff;
      res_y_in      = res_y_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               res_x_in      = '0;
               res_y_in      = '0;
               res_stored_in = q_ctrl.push;
               res_valid_in  = q_ctrl.pop;
               state_in      = q_ctrl.pop ? S_LOAD : S_DONE;
            end
         end
         S_LOAD: begin
            state_in = S_X;
         end
         S_X: begin
            if (sc_done) begin
               res_x_in = sc_pos;
               state_in = S_Y;
            end
         end
         S_Y: begin
            if (sc_done) begin
               res_y_in = sc_pos;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      res_valid_ff  <= res_valid_in;
      res_stored_ff <= res_stored_in;
      res_x_ff      <= res_x_in;
      res_y_ff      <= res_y_in;
   end

   // output register: hold while the receiver stalls
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_read_valid_ff <= res_valid_ff;
         rsp_button_ff     <= (res_valid_ff && q_rd_data.down) ? BTN_DOWN : BTN_UP;
         rsp_x_ff          <= res_x_ff;
         rsp_y_ff          <= res_y_ff;
         rsp_stored_ff     <= res_stored_ff;
         rsp_count_ff      <= COUNT_W'(q_stat.count);
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.read_valid   = rsp_read_valid_ff;
   assign rsp_chan.pen_button   = rsp_button_ff;
   assign rsp_chan.x_pos        = rsp_x_ff;
   assign rsp_chan.y_pos        = rsp_y_ff;
   assign rsp_chan.event_stored = rsp_stored_ff;
   assign rsp_chan.event_count  = rsp_count_ff;

   `TPEQ_ASSERT_SAME(a_rsp_empty_zero, clock, reset, rsp_chan.valid && !rsp_chan.read_valid, (rsp_chan.x_pos == '0) && (rsp_chan.y_pos == '0) && (rsp_chan.pen_button == BTN_UP), "non-read result carries data")
   `TPEQ_ASSERT_SAME(a_rsp_kind, clock, reset, rsp_chan.valid, !(rsp_chan.read_valid && rsp_chan.event_stored), "result both read and stored")
   `TPEQ_ASSERT_NEXT(a_empty_read_done, clock, reset, req_accept && req_chan.action && q_stat.empty, state_ff == S_DONE, "empty read did not finish at once")
   `TPEQ_ASSERT_SAME(a_scaler_done_state, clock, reset, sc_done, (state_ff == S_X) || (state_ff == S_Y), "scaler finished outside a scaling step")

endmodule
